// ===== rtl/http_request_head_parser_defines.svh =====
// Assertion helpers for the request head parser checkers.
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrp_pkg.sv =====
package hrp_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CMP_W      = (COUNT_BITS > 24) ? COUNT_BITS : 24;

    localparam logic [COUNT_BITS-1:0] BODY_MAX = '1;
    localparam logic [24:0]           NUM_SAT  = 25'h1FF_FFFF;
    localparam logic [3:0]            KEY_LEN  = 4'd15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAX_METHOD  = 2'd0;
    localparam logic [1:0] REG_MAX_PATH    = 2'd1;
    localparam logic [1:0] REG_MAX_VERSION = 2'd2;
    localparam logic [1:0] REG_MAX_CL      = 2'd3;

    localparam logic [7:0]  RST_MAX_METHOD  = 8'd15;
    localparam logic [9:0]  RST_MAX_PATH    = 10'd255;
    localparam logic [7:0]  RST_MAX_VERSION = 8'd15;
    localparam logic [23:0] RST_MAX_CL      = 24'd262144;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADERS = 3'd3,
        PH_BODY    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CLS_METHOD  = 3'd0,
        CLS_PATH    = 3'd1,
        CLS_VERSION = 3'd2,
        CLS_HEADER  = 3'd3,
        CLS_BODY    = 3'd4,
        CLS_SEP     = 3'd5
    } t_class;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_METHOD_LEN  = 3'd1,
        ERR_PATH_LEN    = 3'd2,
        ERR_VERSION_LEN = 3'd3,
        ERR_CONTENT_LEN = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        NUM_NONE   = 2'd0,
        NUM_SKIP   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_DONE   = 2'd3
    } t_num;

    typedef struct packed {
        logic [7:0]  max_method;
        logic [9:0]  max_path;
        logic [7:0]  max_version;
        logic [23:0] max_cl;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  match_index;
        t_num        num_phase;
        logic [24:0] value;
        logic        negative;
    } t_scan;

    typedef struct packed {
        t_phase                phase;
        logic [9:0]            field_count;
        logic                  cr_held;
        logic                  line_empty;
        t_scan                 scan;
        logic [COUNT_BITS-1:0] body;
        t_err                  err;
    } t_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_class      byte_class;
        logic        field_end;
        t_err        error_code;
        logic        headers_done;
        logic        request_complete;
        logic [23:0] declared_len;
        logic [23:0] body_count;
        logic        last_of_run;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_METHOD,
        field_count: 10'd0,
        cr_held:     1'b0,
        line_empty:  1'b1,
        scan:        '{match_index: 4'd0, num_phase: NUM_NONE, value: 25'd0, negative: 1'b0},
        body:        '0,
        err:         ERR_NONE
    };

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        unique case (idx)
            4'd0:    key_char = "c";
            4'd1:    key_char = "o";
            4'd2:    key_char = "n";
            4'd3:    key_char = "t";
            4'd4:    key_char = "e";
            4'd5:    key_char = "n";
            4'd6:    key_char = "t";
            4'd7:    key_char = "-";
            4'd8:    key_char = "l";
            4'd9:    key_char = "e";
            4'd10:   key_char = "n";
            4'd11:   key_char = "g";
            4'd12:   key_char = "t";
            4'd13:   key_char = "h";
            4'd14:   key_char = ":";
            default: key_char = 8'h00;
        endcase
    endfunction

    // reported length: zero when negative, clipped to 24 bits
    function automatic logic [23:0] cl_value(input logic neg, input logic [24:0] val);
        if (neg) begin
            cl_value = 24'd0;
        end else if (val[24]) begin
            cl_value = 24'hFF_FFFF;
        end else begin
            cl_value = val[23:0];
        end
    endfunction

    function automatic logic count_reached(input logic [COUNT_BITS-1:0] body,
                                           input logic [23:0] cl);
        count_reached = CMP_W'(body) >= CMP_W'(cl);
    endfunction

    function automatic t_class phase_class(input t_phase ph);
        unique case (ph)
            PH_METHOD:  phase_class = CLS_METHOD;
            PH_PATH:    phase_class = CLS_PATH;
            PH_VERSION: phase_class = CLS_VERSION;
            PH_HEADERS: phase_class = CLS_HEADER;
            default:    phase_class = CLS_BODY;
        endcase
    endfunction

    function automatic t_result make_res(input logic [7:0] b, input t_class cls,
                                         input logic fe, input t_err err,
                                         input logic hd, input logic done,
                                         input logic [23:0] cl,
                                         input logic [23:0] bc);
        t_result r;
        r.out_byte         = b;
        r.byte_class       = cls;
        r.field_end        = (err == ERR_NONE) ? fe : 1'b0;
        r.error_code       = err;
        r.headers_done     = hd;
        r.request_complete = done;
        r.declared_len     = cl;
        r.body_count       = bc;
        r.last_of_run      = 1'b0;
        make_res = r;
    endfunction

endpackage

// ===== rtl/hrp_hdr_scan.sv =====
// Content-length key match and number decode for one header byte.
module hrp_hdr_scan (
    input  logic [7:0]          i_byte,
    input  hrp_pkg::t_scan      i_scan,
    input  logic [23:0]         i_max_cl,
    output hrp_pkg::t_scan      o_scan,
    output logic                o_err
);

    logic [7:0]  low_byte;
    logic        is_digit;
    logic [28:0] acc;
    logic [24:0] acc_sat;
    logic [3:0]  match_inc;

    assign low_byte  = (i_byte >= "A" && i_byte <= "Z") ? i_byte + 8'd32 : i_byte;
    assign is_digit  = (i_byte >= "0") && (i_byte <= "9");
    assign match_inc = i_scan.match_index + 4'd1;

    // value * 10 + digit, clipped at the 25-bit ceiling
    assign acc     = ({4'd0, i_scan.value} << 3) + ({4'd0, i_scan.value} << 1)
                   + {25'd0, i_byte[3:0]};
    assign acc_sat = (acc > {4'd0, hrp_pkg::NUM_SAT}) ? hrp_pkg::NUM_SAT : acc[24:0];

    always_comb begin
        o_scan = i_scan;
        o_err  = 1'b0;
        unique case (i_scan.num_phase)
            hrp_pkg::NUM_NONE: begin
                if (i_scan.match_index < hrp_pkg::KEY_LEN &&
                    low_byte == hrp_pkg::key_char(i_scan.match_index)) begin
                    o_scan.match_index = match_inc;
                    if (match_inc == hrp_pkg::KEY_LEN) begin
                        o_scan.num_phase = hrp_pkg::NUM_SKIP;
                    end
                end else begin
                    o_scan.match_index = (low_byte == "c") ? 4'd1 : 4'd0;
                end
            end
            hrp_pkg::NUM_DONE: begin
            end
            default: begin
                priority if (i_scan.num_phase == hrp_pkg::NUM_SKIP &&
                             (i_byte == hrp_pkg::CH_SP || i_byte == hrp_pkg::CH_TAB)) begin
                end else if (i_scan.num_phase == hrp_pkg::NUM_SKIP &&
                             i_byte == hrp_pkg::CH_PLUS) begin
                    o_scan.num_phase = hrp_pkg::NUM_DIGITS;
                end else if (i_scan.num_phase == hrp_pkg::NUM_SKIP &&
                             i_byte == hrp_pkg::CH_MINUS) begin
                    o_scan.negative  = 1'b1;
                    o_scan.num_phase = hrp_pkg::NUM_DIGITS;
                end else if (is_digit) begin
                    o_scan.num_phase = hrp_pkg::NUM_DIGITS;
                    o_scan.value     = acc_sat;
                    o_err = i_scan.negative ? (acc_sat != 25'd0)
                                            : (acc_sat > {1'b0, i_max_cl});
                end else begin
                    o_scan.num_phase = hrp_pkg::NUM_DONE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/hrp_core.sv =====
// Parser state and per-byte step: up to two results per byte.
module hrp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data,
    input  logic              i_first,
    input  hrp_pkg::t_cfg     i_cfg,
    output logic [1:0]        o_cnt,
    output hrp_pkg::t_result  o_res0,
    output hrp_pkg::t_result  o_res1
);

    hrp_pkg::t_state  r_state;
    hrp_pkg::t_state  n_state;
    hrp_pkg::t_state  cur;
    hrp_pkg::t_state  pre;
    hrp_pkg::t_scan   scan_next;
    logic             scan_err;
    hrp_pkg::t_result cr_res;
    hrp_pkg::t_result b_res;
    hrp_pkg::t_result res0;
    hrp_pkg::t_result res1;
    logic             has_cr;
    logic             has_b;
    logic [1:0]       cnt;
    logic [9:0]       lim;
    logic [23:0]      cl_cur;
    logic [23:0]      bc_cur;

    assign cur    = i_first ? hrp_pkg::STATE_RESET : r_state;
    assign cl_cur = hrp_pkg::cl_value(cur.scan.negative, cur.scan.value);
    assign bc_cur = 24'(cur.body);

    hrp_hdr_scan u_scan (
        .i_byte   (i_data),
        .i_scan   (cur.scan),
        .i_max_cl (i_cfg.max_cl),
        .o_scan   (scan_next),
        .o_err    (scan_err)
    );

    always_comb begin
        n_state = cur;
        pre     = cur;
        cr_res  = '0;
        b_res   = '0;
        res0    = '0;
        res1    = '0;
        has_cr  = 1'b0;
        has_b   = 1'b0;
        cnt     = 2'd0;
        lim     = (cur.phase == hrp_pkg::PH_METHOD) ? {2'd0, i_cfg.max_method}
                                                    : i_cfg.max_path;
        priority if (cur.err != hrp_pkg::ERR_NONE) begin
            // stopped: echo bytes with the frozen phase
            res0 = hrp_pkg::make_res(i_data, hrp_pkg::phase_class(cur.phase), 1'b0,
                                     cur.err, 1'b0, 1'b0, cl_cur, bc_cur);
            cnt  = 2'd1;
        end else if (cur.cr_held && i_data == hrp_pkg::CH_LF) begin
            n_state.cr_held = 1'b0;
            cnt = 2'd2;
            priority if (cur.phase == hrp_pkg::PH_VERSION) begin
                res0 = hrp_pkg::make_res(hrp_pkg::CH_CR, hrp_pkg::CLS_SEP, 1'b1,
                                         hrp_pkg::ERR_NONE, 1'b0, 1'b0, cl_cur, bc_cur);
                res1 = hrp_pkg::make_res(i_data, hrp_pkg::CLS_SEP, 1'b0,
                                         hrp_pkg::ERR_NONE, 1'b0, 1'b0, cl_cur, bc_cur);
                n_state.phase       = hrp_pkg::PH_HEADERS;
                n_state.field_count = 10'd0;
                n_state.line_empty  = 1'b1;
            end else if (cur.line_empty) begin
                // empty line: end of the header block
                res0 = hrp_pkg::make_res(hrp_pkg::CH_CR, hrp_pkg::CLS_SEP, 1'b0,
                                         hrp_pkg::ERR_NONE, 1'b0, 1'b0, cl_cur, bc_cur);
                res1 = hrp_pkg::make_res(i_data, hrp_pkg::CLS_SEP, 1'b0,
                                         hrp_pkg::ERR_NONE, 1'b1,
                                         hrp_pkg::count_reached(cur.body, cl_cur),
                                         cl_cur, bc_cur);
                n_state.phase = hrp_pkg::PH_BODY;
            end else begin
                res0 = hrp_pkg::make_res(hrp_pkg::CH_CR, hrp_pkg::CLS_SEP, 1'b1,
                                         hrp_pkg::ERR_NONE, 1'b0, 1'b0, cl_cur, bc_cur);
                res1 = hrp_pkg::make_res(i_data, hrp_pkg::CLS_SEP, 1'b0,
                                         hrp_pkg::ERR_NONE, 1'b0, 1'b0, cl_cur, bc_cur);
                n_state.line_empty  = 1'b1;
                n_state.field_count = 10'd0;
            end
        end else begin
            // a held CR not followed by LF is a plain byte of its field
            if (cur.cr_held) begin
                pre.cr_held = 1'b0;
                if (cur.phase == hrp_pkg::PH_VERSION) begin
                    pre.field_count = cur.field_count + 10'd1;
                end else begin
                    pre.line_empty = 1'b0;
                end
                has_cr = 1'b1;
                cr_res = hrp_pkg::make_res(hrp_pkg::CH_CR, hrp_pkg::phase_class(cur.phase),
                                           1'b0, hrp_pkg::ERR_NONE, 1'b0, 1'b0,
                                           cl_cur, bc_cur);
            end
            n_state = pre;
            has_b   = 1'b1;
            unique case (pre.phase)
                hrp_pkg::PH_METHOD, hrp_pkg::PH_PATH: begin
                    priority if (pre.field_count >= lim) begin
                        n_state.err = (pre.phase == hrp_pkg::PH_METHOD) ?
                                      hrp_pkg::ERR_METHOD_LEN : hrp_pkg::ERR_PATH_LEN;
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::phase_class(pre.phase),
                                                  1'b0, n_state.err, 1'b0, 1'b0,
                                                  cl_cur, bc_cur);
                    end else if (i_data == hrp_pkg::CH_SP) begin
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::CLS_SEP, 1'b1,
                                                  hrp_pkg::ERR_NONE, 1'b0, 1'b0,
                                                  cl_cur, bc_cur);
                        n_state.phase = (pre.phase == hrp_pkg::PH_METHOD) ?
                                        hrp_pkg::PH_PATH : hrp_pkg::PH_VERSION;
                        n_state.field_count = 10'd0;
                    end else begin
                        n_state.field_count = pre.field_count + 10'd1;
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::phase_class(pre.phase),
                                                  1'b0, hrp_pkg::ERR_NONE, 1'b0, 1'b0,
                                                  cl_cur, bc_cur);
                    end
                end
                hrp_pkg::PH_VERSION: begin
                    priority if (pre.field_count >= {2'd0, i_cfg.max_version}) begin
                        n_state.err = hrp_pkg::ERR_VERSION_LEN;
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::CLS_VERSION, 1'b0,
                                                  hrp_pkg::ERR_VERSION_LEN, 1'b0, 1'b0,
                                                  cl_cur, bc_cur);
                    end else if (i_data == hrp_pkg::CH_CR) begin
                        n_state.cr_held = 1'b1;
                        has_b = 1'b0;
                    end else begin
                        n_state.field_count = pre.field_count + 10'd1;
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::CLS_VERSION, 1'b0,
                                                  hrp_pkg::ERR_NONE, 1'b0, 1'b0,
                                                  cl_cur, bc_cur);
                    end
                end
                hrp_pkg::PH_HEADERS: begin
                    n_state.scan = scan_next;
                    if (scan_err) begin
                        n_state.err = hrp_pkg::ERR_CONTENT_LEN;
                    end
                    if (i_data == hrp_pkg::CH_CR && !scan_err) begin
                        n_state.cr_held = 1'b1;
                        has_b = 1'b0;
                    end else begin
                        n_state.line_empty = 1'b0;
                        b_res = hrp_pkg::make_res(i_data, hrp_pkg::CLS_HEADER, 1'b0,
                                                  n_state.err, 1'b0, 1'b0,
                                                  hrp_pkg::cl_value(scan_next.negative,
                                                                    scan_next.value),
                                                  bc_cur);
                    end
                end
                default: begin
                    n_state.body = (pre.body == hrp_pkg::BODY_MAX) ? pre.body
                                                                   : pre.body + 1'b1;
                    b_res = hrp_pkg::make_res(i_data, hrp_pkg::CLS_BODY, 1'b0,
                                              hrp_pkg::ERR_NONE, 1'b0,
                                              hrp_pkg::count_reached(n_state.body, cl_cur),
                                              cl_cur, 24'(n_state.body));
                end
            endcase
            if (has_cr) begin
                res0 = cr_res;
                res1 = b_res;
                cnt  = has_b ? 2'd2 : 2'd1;
            end else begin
                res0 = b_res;
                cnt  = has_b ? 2'd1 : 2'd0;
            end
        end
        if (cnt == 2'd2) begin
            res1.last_of_run = 1'b1;
        end else begin
            res0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrp_pkg::STATE_RESET;
        end else if (i_take) begin
            r_state <= n_state;
        end
    end

    assign o_cnt  = i_take ? cnt : 2'd0;
    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

// ===== rtl/hrp_res_queue.sv =====
// Four-entry result queue; takes up to two results a cycle, gives one when read.
module hrp_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  hrp_pkg::t_result  i_res0,
    input  hrp_pkg::t_result  i_res1,
    output logic              o_valid,
    input  logic              i_ready,
    output hrp_pkg::t_result  o_res,
    output logic              o_room
);

    hrp_pkg::t_result r_entry [4];
    logic [1:0]       r_head;
    logic [1:0]       r_tail;
    logic [2:0]       r_count;
    logic [1:0]       tail_p1;
    logic             pop;

    assign tail_p1 = r_tail + 2'd1;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_entry[r_head];
    // two free slots guaranteed without looking at this cycle's pop
    assign o_room  = (r_count <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_entry[r_tail] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_entry[tail_p1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_tail  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_tail  <= r_tail + i_push_cnt;
            r_count <= r_count + {1'b0, i_push_cnt} - {2'd0, pop};
            if (pop) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

endmodule

// ===== rtl/http_request_head_parser.sv =====
// Request head parser: one request byte per item in, one tagged result per item out.
// Each accepted byte gives zero, one or two results: a CR in the version line or
// a header line gives nothing until the next byte shows whether it ends the line,
// and that next byte then yields the CR and itself, unless it is held as a new CR.
// The block takes one byte per cycle whenever its four-entry result queue holds two or
// fewer results, so one-result bytes stream at one per cycle while the output is
// ready; a two-result byte writes both into the queue at once. An accepted byte
// passes the input register, then the step logic writes its results into the queue.
// An error is sticky until a byte with first_byte set arrives and restarts parsing.
// Limits and the maximum content length are written over the APB port at byte
// addresses 0, 4, 8 and 12 and should be changed only while the block is idle.
module http_request_head_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_byte_class,
    output logic        o_field_end,
    output logic [2:0]  o_error_code,
    output logic        o_headers_done,
    output logic        o_request_complete,
    output logic [23:0] o_declared_len,
    output logic [23:0] o_body_count,
    output logic        o_last_of_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_first;
    hrp_pkg::t_cfg    r_cfg;
    logic             take;
    logic             room;
    logic [1:0]       push_cnt;
    hrp_pkg::t_result res0;
    hrp_pkg::t_result res1;
    hrp_pkg::t_result head;
    logic             cfg_wr;

    assign take       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_method  <= hrp_pkg::RST_MAX_METHOD;
            r_cfg.max_path    <= hrp_pkg::RST_MAX_PATH;
            r_cfg.max_version <= hrp_pkg::RST_MAX_VERSION;
            r_cfg.max_cl      <= hrp_pkg::RST_MAX_CL;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                hrp_pkg::REG_MAX_METHOD:  r_cfg.max_method  <= pwdata[7:0];
                hrp_pkg::REG_MAX_PATH:    r_cfg.max_path    <= pwdata[9:0];
                hrp_pkg::REG_MAX_VERSION: r_cfg.max_version <= pwdata[7:0];
                default:                  r_cfg.max_cl      <= pwdata[23:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hrp_pkg::REG_MAX_METHOD:  prdata = {24'd0, r_cfg.max_method};
            hrp_pkg::REG_MAX_PATH:    prdata = {22'd0, r_cfg.max_path};
            hrp_pkg::REG_MAX_VERSION: prdata = {24'd0, r_cfg.max_version};
            default:                  prdata = {8'd0, r_cfg.max_cl};
        endcase
    end

    hrp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (r_in_data),
        .i_first (r_in_first),
        .i_cfg   (r_cfg),
        .o_cnt   (push_cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    hrp_res_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (head),
        .o_room     (room)
    );

    assign o_out_byte         = head.out_byte;
    assign o_byte_class       = head.byte_class;
    assign o_field_end        = head.field_end;
    assign o_error_code       = head.error_code;
    assign o_headers_done     = head.headers_done;
    assign o_request_complete = head.request_complete;
    assign o_declared_len     = head.declared_len;
    assign o_body_count       = head.body_count;
    assign o_last_of_run      = head.last_of_run;

endmodule

// ===== rtl/hrp_checker.sv =====
`include "http_request_head_parser_defines.svh"

module hrp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  o_out_byte,
    input  logic [2:0]  o_byte_class,
    input  logic        o_field_end,
    input  logic [2:0]  o_error_code,
    input  logic        o_headers_done,
    input  logic        o_request_complete,
    input  logic [23:0] o_declared_len,
    input  logic [23:0] o_body_count,
    input  logic        o_last_of_run
);

    logic [65:0] out_item;
    logic        stalled;
    logic        is_sep;
    logic        no_err;
    logic        fe_ok;
    logic        hd_ok;
    logic        done_ok;

    assign out_item = {o_out_byte, o_byte_class, o_field_end, o_error_code, o_headers_done,
                       o_request_complete, o_declared_len, o_body_count, o_last_of_run};
    assign stalled  = o_out_valid && !i_out_ready;
    assign is_sep   = (o_byte_class == hrp_pkg::CLS_SEP);
    assign no_err   = (o_error_code == hrp_pkg::ERR_NONE);
    assign fe_ok    = is_sep && no_err && !o_headers_done;
    assign hd_ok    = is_sep && (o_out_byte == hrp_pkg::CH_LF) && o_last_of_run;
    assign done_ok  = no_err && (o_byte_class == hrp_pkg::CLS_BODY || (is_sep && o_headers_done));

    `HRP_ASSERT_NEXT(a_stall_hold, stalled, o_out_valid && $stable(out_item), "payload moved")
    `HRP_ASSERT_NOW(a_field_end_sep, o_out_valid && o_field_end, fe_ok, "bad field end")
    `HRP_ASSERT_NOW(a_hdr_done_lf, o_out_valid && o_headers_done, hd_ok, "bad header end")
    `HRP_ASSERT_NOW(a_complete_ok, o_out_valid && o_request_complete, done_ok, "bad completion")

endmodule

bind http_request_head_parser hrp_checker u_checker (.*);

// ===== bench/tb_http_request_head_parser.sv =====
`timescale 1ns / 100ps

module tb_http_request_head_parser;
    import hrp_pkg::*;

    localparam int ITEM_TARGET  = 1750;
    localparam int PHASE_ITEMS  = 250;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 40;
    localparam logic [119:0] CL_KEY = "content-length:";

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_first_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_byte_class;
    logic        o_field_end;
    logic [2:0]  o_error_code;
    logic        o_headers_done;
    logic        o_request_complete;
    logic [23:0] o_declared_len;
    logic [23:0] o_body_count;
    logic        o_last_of_run;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    http_request_head_parser u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_byte_class       (o_byte_class),
        .o_field_end        (o_field_end),
        .o_error_code       (o_error_code),
        .o_headers_done     (o_headers_done),
        .o_request_complete (o_request_complete),
        .o_declared_len     (o_declared_len),
        .o_body_count       (o_body_count),
        .o_last_of_run      (o_last_of_run),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // parser model state and register copies
    t_phase      ph;
    logic [9:0]  fcount;
    logic        cr_pend;
    logic        line_empty;
    logic [3:0]  key_idx;
    t_num        num_ph;
    logic [24:0] num_val;
    logic        num_neg;
    logic [23:0] body_cnt;
    t_err        err_st;

    logic [7:0]  lim_method  = RST_MAX_METHOD;
    logic [9:0]  lim_path    = RST_MAX_PATH;
    logic [7:0]  lim_version = RST_MAX_VERSION;
    logic [23:0] lim_cl      = RST_MAX_CL;

    t_result     step_tags[2];
    int          step_n;
    t_result     expected_tags[$];
    logic [7:0]  req_bytes[$];

    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          in_idle_on  = 1'b0;
    bit          out_idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- parser model ----------------

    function automatic logic [23:0] reported_len();
        if (num_neg) return 24'd0;
        if (num_val > 25'hFF_FFFF) return 24'hFF_FFFF;
        return num_val[23:0];
    endfunction

    task automatic clear_parse();
        ph = PH_METHOD;
        fcount = 10'd0;
        cr_pend = 1'b0;
        line_empty = 1'b1;
        key_idx = 4'd0;
        num_ph = NUM_NONE;
        num_val = 25'd0;
        num_neg = 1'b0;
        body_cnt = 24'd0;
        err_st = ERR_NONE;
    endtask

    task automatic note_tag(input logic [7:0] b, input t_class cls, input logic fe,
                            input logic hd);
        t_result r;
        logic [23:0] clen;
        clen = reported_len();
        r.out_byte         = b;
        r.byte_class       = cls;
        r.field_end        = (err_st == ERR_NONE) ? fe : 1'b0;
        r.error_code       = err_st;
        r.headers_done     = hd;
        r.request_complete = (ph == PH_BODY) && (err_st == ERR_NONE) && (body_cnt >= clen);
        r.declared_len     = clen;
        r.body_count       = body_cnt;
        r.last_of_run      = 1'b0;
        step_tags[step_n]  = r;
        step_n++;
    endtask

    task automatic scan_length_key(input logic [7:0] b);
        logic [7:0]  low;
        logic [63:0] acc;
        low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (num_ph == NUM_NONE) begin
            if (key_idx < KEY_LEN && low == CL_KEY[119 - 8 * key_idx -: 8]) begin
                key_idx++;
                if (key_idx == KEY_LEN) num_ph = NUM_SKIP;
            end else begin
                key_idx = (low == "c") ? 4'd1 : 4'd0;
            end
            return;
        end
        if (num_ph == NUM_DONE) return;
        if (num_ph == NUM_SKIP) begin
            if (b == CH_SP || b == CH_TAB) return;
            if (b == CH_PLUS) begin
                num_ph = NUM_DIGITS;
                return;
            end
            if (b == CH_MINUS) begin
                num_neg = 1'b1;
                num_ph = NUM_DIGITS;
                return;
            end
        end
        if (b >= "0" && b <= "9") begin
            num_ph = NUM_DIGITS;
            acc = 64'(num_val) * 64'd10 + 64'(b - "0");
            if (acc > 64'h1FF_FFFF) acc = 64'h1FF_FFFF;
            num_val = acc[24:0];
            if (num_neg ? (num_val != 25'd0) : (num_val > {1'b0, lim_cl}))
                err_st = ERR_CONTENT_LEN;
        end else begin
            num_ph = NUM_DONE;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first);
        logic [9:0] lim;
        bit line_closed;
        step_n = 0;
        line_closed = 1'b0;
        if (first) clear_parse();
        if (err_st != ERR_NONE) begin
            note_tag(b, t_class'(ph), 1'b0, 1'b0);
        end else begin
            if (cr_pend) begin
                cr_pend = 1'b0;
                if (b == CH_LF) begin
                    line_closed = 1'b1;
                    if (ph == PH_VERSION) begin
                        note_tag(CH_CR, CLS_SEP, 1'b1, 1'b0);
                        ph = PH_HEADERS;
                        fcount = 10'd0;
                        line_empty = 1'b1;
                        note_tag(b, CLS_SEP, 1'b0, 1'b0);
                    end else if (line_empty) begin
                        note_tag(CH_CR, CLS_SEP, 1'b0, 1'b0);
                        ph = PH_BODY;
                        note_tag(b, CLS_SEP, 1'b0, 1'b1);
                    end else begin
                        note_tag(CH_CR, CLS_SEP, 1'b1, 1'b0);
                        line_empty = 1'b1;
                        fcount = 10'd0;
                        note_tag(b, CLS_SEP, 1'b0, 1'b0);
                    end
                end else begin
                    // CR did not end the line: it belongs to the field
                    if (ph == PH_VERSION) fcount++;
                    else line_empty = 1'b0;
                    note_tag(CH_CR, t_class'(ph), 1'b0, 1'b0);
                end
            end
            if (!line_closed) begin
                case (ph)
                    PH_METHOD, PH_PATH: begin
                        lim = (ph == PH_METHOD) ? {2'b00, lim_method} : lim_path;
                        if (fcount >= lim) begin
                            err_st = (ph == PH_METHOD) ? ERR_METHOD_LEN : ERR_PATH_LEN;
                            note_tag(b, t_class'(ph), 1'b0, 1'b0);
                        end else if (b == CH_SP) begin
                            note_tag(b, CLS_SEP, 1'b1, 1'b0);
                            ph = (ph == PH_METHOD) ? PH_PATH : PH_VERSION;
                            fcount = 10'd0;
                        end else begin
                            fcount++;
                            note_tag(b, t_class'(ph), 1'b0, 1'b0);
                        end
                    end
                    PH_VERSION: begin
                        if (fcount >= {2'b00, lim_version}) begin
                            err_st = ERR_VERSION_LEN;
                            note_tag(b, CLS_VERSION, 1'b0, 1'b0);
                        end else if (b == CH_CR) begin
                            cr_pend = 1'b1;
                        end else begin
                            fcount++;
                            note_tag(b, CLS_VERSION, 1'b0, 1'b0);
                        end
                    end
                    PH_HEADERS: begin
                        scan_length_key(b);
                        if (b == CH_CR && err_st == ERR_NONE) begin
                            cr_pend = 1'b1;
                        end else begin
                            line_empty = 1'b0;
                            note_tag(b, CLS_HEADER, 1'b0, 1'b0);
                        end
                    end
                    default: begin
                        if (body_cnt != '1) body_cnt++;
                        note_tag(b, CLS_BODY, 1'b0, 1'b0);
                    end
                endcase
            end
        end
        if (step_n > 0) step_tags[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++) expected_tags.push_back(step_tags[i]);
    endtask

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input longint unsigned want_v,
                                        input longint unsigned got_v);
        if (want_v != got_v) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
                         want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tags.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual byte %0h",
                             $time, o_out_byte);
                mismatches++;
            end else begin
                want = expected_tags.pop_front();
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("byte_class", want.byte_class, o_byte_class);
                check_field("field_end", want.field_end, o_field_end);
                check_field("error_code", want.error_code, o_error_code);
                check_field("headers_done", want.headers_done, o_headers_done);
                check_field("request_complete", want.request_complete, o_request_complete);
                check_field("declared_len", want.declared_len, o_declared_len);
                check_field("body_count", want.body_count, o_body_count);
                check_field("last_of_run", want.last_of_run, o_last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stalls, one draw per item
    always begin : drive_out_ready
        int stall;
        @(negedge i_clk);
        stall = out_idle_on ? $urandom_range(0, 12) : 0;
        if (stall > 0) begin
            i_out_ready = 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        i_out_ready = 1'b1;
        do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
    end

    // ---------------- stimulus helpers (entered at a falling edge) ----------------

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_data_byte  = b;
        i_first_byte = first;
        do @(posedge i_clk); while (!o_in_ready);
        parse_byte(b, first);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input int count, input bit restart);
        for (int i = 0; i < count; i++) send_byte(req_bytes[i], restart && i == 0);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_tags.size() != 0) @(negedge i_clk);
        // a trailing CR produces nothing yet; let the pipeline settle
        repeat (6) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MAX_METHOD:  lim_method  = val[7:0];
            REG_MAX_PATH:    lim_path    = val[9:0];
            REG_MAX_VERSION: lim_version = val[7:0];
            default:         lim_cl      = val[23:0];
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limits(input int m, input int p, input int v, input int c);
        wait_drained();
        apb_write(REG_MAX_METHOD, 32'(m));
        apb_write(REG_MAX_PATH, 32'(p));
        apb_write(REG_MAX_VERSION, 32'(v));
        apb_write(REG_MAX_CL, 32'(c));
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endtask

    task automatic push_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endtask

    function automatic int pick_len(input int lim, input int cap);
        if (lim <= 40 && $urandom_range(0, 11) == 0) return lim + $urandom_range(0, 2);
        return $urandom_range(0, (lim - 1 < cap) ? lim - 1 : cap);
    endfunction

    task automatic push_field(input int len, input bit is_ver);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            if (is_ver && i + 1 < len && $urandom_range(0, 11) == 0) begin
                req_bytes.push_back(CH_CR);
                req_bytes.push_back("v");
                i++;
            end else begin
                c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(33, 126));
                if ((!is_ver && c == CH_SP) || (is_ver && c == CH_CR)) c = "x";
                req_bytes.push_back(c);
            end
        end
    endtask

    task automatic push_header_line();
        int len;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                req_bytes.push_back(CH_CR);
                req_bytes.push_back("q");
            end else if ($urandom_range(0, 15) == 0) begin
                req_bytes.push_back(CH_LF);
            end else begin
                req_bytes.push_back(8'($urandom_range(32, 126)));
            end
        end
    endtask

    // returns the length the body should honor, or -1 when it does not matter
    task automatic push_length_line(output int clv);
        logic [7:0] c;
        int sel;
        int v;
        bit neg;
        bit keyed;
        neg = 1'b0;
        keyed = 1'b1;
        if ($urandom_range(0, 3) == 0) push_str("X-T: ");
        if ($urandom_range(0, 9) == 0) req_bytes.push_back("c");
        for (int i = 0; i < 15; i++) begin
            c = CL_KEY[119 - 8 * i -: 8];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            if (i == 14 && $urandom_range(0, 11) == 0) keyed = 1'b0;
            else req_bytes.push_back(c);
        end
        repeat ($urandom_range(0, 3))
            req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        sel = $urandom_range(0, 9);
        if (sel == 7) begin
            req_bytes.push_back(CH_PLUS);
        end else if (sel >= 8) begin
            req_bytes.push_back(CH_MINUS);
            neg = 1'b1;
        end
        sel = $urandom_range(0, 9);
        v = -1;
        if (sel == 0) begin
            v = 0;
        end else if (sel == 1) begin
            repeat ($urandom_range(8, 12)) req_bytes.push_back(8'($urandom_range(48, 57)));
        end else begin
            if (sel == 2) v = int'(lim_cl) + $urandom_range(0, 1);
            else v = $urandom_range(0, 40);
            if (sel == 3) push_str("00");
            push_str($sformatf("%0d", v));
        end
        if ($urandom_range(0, 4) == 0) push_str("x9");
        if (!keyed) clv = -1;
        else if (neg && v != 0) clv = -1;
        else clv = v;
    endtask

    task automatic build_request();
        int n_hdr;
        int cl_at;
        int clv;
        int dummy;
        int blen;
        req_bytes.delete();
        push_field(pick_len(lim_method, 6), 1'b0);
        req_bytes.push_back(CH_SP);
        // length text in the path must not be picked up
        if ($urandom_range(0, 19) == 0) push_str("/content-length:7");
        else push_field(pick_len(lim_path, 12), 1'b0);
        req_bytes.push_back(CH_SP);
        push_field(pick_len(lim_version, 8), 1'b1);
        push_crlf();
        n_hdr = $urandom_range(0, 4);
        cl_at = $urandom_range(0, 4);
        clv = -1;
        for (int i = 0; i < n_hdr; i++) begin
            if (i == cl_at) push_length_line(clv);
            else if ($urandom_range(0, 5) == 0) push_length_line(dummy);
            else push_header_line();
            push_crlf();
        end
        push_crlf();
        if (clv >= 0 && clv <= 30) blen = clv + $urandom_range(0, 2);
        else blen = $urandom_range(0, 6);
        repeat (blen) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // ---------------- tests ----------------

    task automatic test_basic_request();
        req_bytes.delete();
        push_str("A B C");
        push_crlf();
        push_crlf();
        push_str("x");
        send_bytes(req_bytes.size(), 1'b1);
    endtask

    task automatic test_restart_held_cr();
        req_bytes.delete();
        req_bytes.push_back(8'hFF);
        req_bytes.push_back(8'h00);
        push_str("  V");
        req_bytes.push_back(CH_CR);
        send_bytes(req_bytes.size(), 1'b1);
        // pending CR is dropped; LF and CR become plain method bytes
        send_byte(CH_LF, 1'b1);
        send_byte(CH_CR, 1'b0);
    endtask

    task automatic test_length_error();
        set_limits(1, RST_MAX_PATH, RST_MAX_VERSION, RST_MAX_CL);
        req_bytes.delete();
        push_str("AB C");
        send_bytes(req_bytes.size(), 1'b1);
    endtask

    task automatic test_random_requests();
        int phase_no;
        int phase_end;
        int cut;
        phase_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            case (phase_no)
                0: set_limits(RST_MAX_METHOD, RST_MAX_PATH, RST_MAX_VERSION, RST_MAX_CL);
                1: set_limits(1, 1, 1, 0);
                2: set_limits(255, 1023, 255, 24'hFF_FFFF);
                default: set_limits($urandom_range(1, 12),
                                    ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1023)
                                                                : $urandom_range(1, 24),
                                    $urandom_range(1, 12),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                                : $urandom_range(0, 40));
            endcase
            in_idle_on  = (phase_no == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            out_idle_on = (phase_no == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end else begin
                    build_request();
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, req_bytes.size())
                                                      : req_bytes.size();
                    send_bytes(cut, 1'b1);
                end
                if ($urandom_range(0, 14) == 0) wait_drained();
            end
            phase_no++;
        end
    endtask

    initial begin
        clear_parse();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_request();
        test_restart_held_cr();
        test_length_error();
        test_random_requests();
        i_in_valid = 1'b0;
        while (expected_tags.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && expected_tags.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
